[rtl/fdc_pkg.sv]
// Package with shared types, constants and the CRC-16/MODBUS byte update.
package fdc_pkg;

    // CRC-16/MODBUS constants.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Frame length limits: the shortest frame and the bytes that are not payload.
    localparam logic [16:0] MIN_FRAME_LEN  = 17'd10;
    localparam logic [16:0] FRAME_OVERHEAD = 17'd9;

    // Default depth of the result queue.
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MASTER_FIRST = 3'd0;
    localparam logic [2:0] CFG_MASTER_SECOND = 3'd1;
    localparam logic [2:0] CFG_SLAVE_FIRST = 3'd2;
    localparam logic [2:0] CFG_SLAVE_SECOND = 3'd3;
    localparam logic [2:0] CFG_LENGTH_ADJUST = 3'd4;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_ACCEPTED = 2'd1,
        KIND_CRC_ERR  = 2'd2,
        KIND_SHORT    = 2'd3
    } kind_t;

    // Configuration as seen by the parser.
    typedef struct packed {
        logic [7:0] master_first;
        logic [7:0] master_second;
        logic [7:0] slave_first;
        logic [7:0] slave_second;
        logic [3:0] length_adjust;
    } cfg_t;

    // One result item.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [7:0]  node_id;
        logic [7:0]  msg_type;
        logic [7:0]  resp_flag;
        logic        from_slave;
        logic [15:0] payload_count;
    } result_t;

    // One byte through the reflected CRC; eight shifts unroll into XOR logic.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[rtl/fdc_parser.sv]
// Front part: header hunt, field capture, CRC check and result classification.
module fdc_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    input  logic [7:0]       rx_byte,
    input  fdc_pkg::cfg_t    cfg,
    output logic             res_valid,
    output fdc_pkg::result_t res
);
    import fdc_pkg::*;

    typedef enum logic [8:0] {
        PH_HUNT    = 9'b000000001,
        PH_ID      = 9'b000000010,
        PH_LEN_HI  = 9'b000000100,
        PH_LEN_LO  = 9'b000001000,
        PH_TYPE    = 9'b000010000,
        PH_FLAG    = 9'b000100000,
        PH_PAYLOAD = 9'b001000000,
        PH_CRC_HI  = 9'b010000000,
        PH_CRC_LO  = 9'b100000000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  prev_byte_reg, prev_byte_next;
    logic        prev_valid_reg, prev_valid_next;
    logic        header_kind_reg, header_kind_next;
    logic [7:0]  id_reg, id_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [16:0] bytes_left_reg, bytes_left_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  flag_reg, flag_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_high_reg, crc_high_next;
    logic [15:0] seen_reg, seen_next;

    logic [15:0] crc_upd;
    logic [16:0] total;
    logic [16:0] left_dec;
    logic [15:0] seen_inc;
    logic        hit_master;
    logic        hit_slave;

    // Shared helpers for the current byte.
    assign crc_upd    = crc_byte(crc_reg, rx_byte);
    assign total      = {1'b0, len_hi_reg, rx_byte} + {13'd0, cfg.length_adjust};
    assign left_dec   = (bytes_left_reg != 17'd0) ? bytes_left_reg - 17'd1 : bytes_left_reg;
    assign seen_inc   = (seen_reg != 16'hFFFF) ? seen_reg + 16'd1 : seen_reg;
    assign hit_master = prev_valid_reg && (prev_byte_reg == cfg.master_first)
                        && (rx_byte == cfg.master_second);
    assign hit_slave  = prev_valid_reg && (prev_byte_reg == cfg.slave_first)
                        && (rx_byte == cfg.slave_second);

    // Next state and result for one accepted byte.
    always_comb
    begin
        phase_next       = phase_reg;
        prev_byte_next   = prev_byte_reg;
        prev_valid_next  = prev_valid_reg;
        header_kind_next = header_kind_reg;
        id_next          = id_reg;
        len_hi_next      = len_hi_reg;
        bytes_left_next  = bytes_left_reg;
        type_next        = type_reg;
        flag_next        = flag_reg;
        crc_next         = crc_reg;
        crc_high_next    = crc_high_reg;
        seen_next        = seen_reg;
        res_valid        = 1'b0;
        res.kind          = KIND_PAYLOAD;
        res.data_byte     = 8'd0;
        res.node_id       = id_reg;
        res.msg_type      = type_reg;
        res.resp_flag     = flag_reg;
        res.from_slave    = header_kind_reg;
        res.payload_count = seen_reg;

        if (byte_valid)
        begin
            case (phase_reg)
                PH_ID:
                begin
                    id_next     = rx_byte;
                    crc_next    = crc_upd;
                    phase_next  = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    len_hi_next = rx_byte;
                    crc_next    = crc_upd;
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    crc_next = crc_upd;
                    if (total < MIN_FRAME_LEN)
                    begin
                        // Frame too short: report and go back to hunting.
                        res_valid       = 1'b1;
                        res.kind        = KIND_SHORT;
                        phase_next      = PH_HUNT;
                        prev_valid_next = 1'b0;
                        prev_byte_next  = 8'd0;
                    end
                    else
                    begin
                        bytes_left_next = total - FRAME_OVERHEAD;
                        phase_next      = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    type_next  = rx_byte;
                    crc_next   = crc_upd;
                    phase_next = PH_FLAG;
                end
                PH_FLAG:
                begin
                    flag_next  = rx_byte;
                    crc_next   = crc_upd;
                    phase_next = (bytes_left_reg != 17'd0) ? PH_PAYLOAD : PH_CRC_HI;
                end
                PH_PAYLOAD:
                begin
                    crc_next          = crc_upd;
                    seen_next         = seen_inc;
                    bytes_left_next   = left_dec;
                    if (left_dec == 17'd0)
                    begin
                        phase_next = PH_CRC_HI;
                    end
                    res_valid         = 1'b1;
                    res.kind          = KIND_PAYLOAD;
                    res.data_byte     = rx_byte;
                    res.payload_count = seen_inc;
                end
                PH_CRC_HI:
                begin
                    crc_high_next = rx_byte;
                    phase_next    = PH_CRC_LO;
                end
                PH_CRC_LO:
                begin
                    res_valid       = 1'b1;
                    res.kind        = ({crc_high_reg, rx_byte} == crc_reg)
                                      ? KIND_ACCEPTED : KIND_CRC_ERR;
                    phase_next      = PH_HUNT;
                    prev_valid_next = 1'b0;
                    prev_byte_next  = 8'd0;
                end
                default:
                begin
                    // Hunting, and any unused phase code.
                    if (hit_master || hit_slave)
                    begin
                        header_kind_next = !hit_master;
                        phase_next       = PH_ID;
                        prev_valid_next  = 1'b0;
                        prev_byte_next   = 8'd0;
                        id_next          = 8'd0;
                        len_hi_next      = 8'd0;
                        bytes_left_next  = 17'd0;
                        type_next        = 8'd0;
                        flag_next        = 8'd0;
                        crc_next         = CRC_INIT;
                        crc_high_next    = 8'd0;
                        seen_next        = 16'd0;
                    end
                    else
                    begin
                        phase_next      = PH_HUNT;
                        prev_byte_next  = rx_byte;
                        prev_valid_next = 1'b1;
                    end
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT;
            prev_byte_reg   <= 8'd0;
            prev_valid_reg  <= 1'b0;
            header_kind_reg <= 1'b0;
            id_reg          <= 8'd0;
            len_hi_reg      <= 8'd0;
            bytes_left_reg  <= 17'd0;
            type_reg        <= 8'd0;
            flag_reg        <= 8'd0;
            crc_reg         <= CRC_INIT;
            crc_high_reg    <= 8'd0;
            seen_reg        <= 16'd0;
        end
        else
        begin
            phase_reg       <= phase_next;
            prev_byte_reg   <= prev_byte_next;
            prev_valid_reg  <= prev_valid_next;
            header_kind_reg <= header_kind_next;
            id_reg          <= id_next;
            len_hi_reg      <= len_hi_next;
            bytes_left_reg  <= bytes_left_next;
            type_reg        <= type_next;
            flag_reg        <= flag_next;
            crc_reg         <= crc_next;
            crc_high_reg    <= crc_high_next;
            seen_reg        <= seen_next;
        end
    end

endmodule

[rtl/fdc_queue.sv]
// Back part: short result queue that holds items until the consumer pops them.
module fdc_queue #(
    parameter int DEPTH = fdc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  fdc_pkg::result_t wr_item,
    input  logic             rd_en,
    output fdc_pkg::result_t rd_item,
    output logic             full,
    output logic             empty
);
    import fdc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    result_t          slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_item = slot_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Item storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

[rtl/frame_deframer_crc16_check.sv]
// Top level of the length-prefixed frame deframer with CRC-16/MODBUS check.
//
//   Channel   Handshake             Payload
//   input     push / full           rx_byte
//   result    empty / pop           kind, data_byte, node_id, msg_type,
//                                   resp_flag, from_slave, payload_count
//   config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// One received byte is taken per cycle while full is low; the parser handles it in the cycle it
// is accepted and any result lands in the queue at that edge, so a result is
// visible in the cycle after its byte. full rises only when the result queue
// (QUEUE_DEPTH items) is full. Reset returns the parser to header hunting,
// empties the queue and loads the default configuration; cfg_ready is always high.
module frame_deframer_crc16_check #(
    parameter int QUEUE_DEPTH = fdc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    input  logic        pop,
    output logic        empty,
    output logic [1:0]  kind,
    output logic [7:0]  data_byte,
    output logic [7:0]  node_id,
    output logic [7:0]  msg_type,
    output logic [7:0]  resp_flag,
    output logic        from_slave,
    output logic [15:0] payload_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import fdc_pkg::*;

    cfg_t    cfg_reg;
    logic    byte_acc;
    logic    res_valid;
    result_t res;
    result_t head;

    assign cfg_ready = 1'b1;
    assign byte_acc  = push && !full;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.master_first  <= 8'hAA;
            cfg_reg.master_second <= 8'h55;
            cfg_reg.slave_first   <= 8'h55;
            cfg_reg.slave_second  <= 8'hAA;
            cfg_reg.length_adjust <= 4'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MASTER_FIRST:  cfg_reg.master_first  <= cfg_data;
                CFG_MASTER_SECOND: cfg_reg.master_second <= cfg_data;
                CFG_SLAVE_FIRST:   cfg_reg.slave_first   <= cfg_data;
                CFG_SLAVE_SECOND:  cfg_reg.slave_second  <= cfg_data;
                CFG_LENGTH_ADJUST: cfg_reg.length_adjust <= cfg_data[3:0];
                default:           ;
            endcase
        end
    end

    // Front part: byte parser.
    fdc_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_acc),
        .rx_byte    (rx_byte),
        .cfg        (cfg_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Back part: result queue.
    fdc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_item (res),
        .rd_en   (pop),
        .rd_item (head),
        .full    (full),
        .empty   (empty)
    );

    // Result ports from the queue head.
    assign kind          = head.kind;
    assign data_byte     = head.data_byte;
    assign node_id       = head.node_id;
    assign msg_type      = head.msg_type;
    assign resp_flag     = head.resp_flag;
    assign from_slave    = head.from_slave;
    assign payload_count = head.payload_count;

endmodule

[verif/fdc_checker.sv]
// Checker for the frame deframer: predicts results from accepted bytes and compares them.
module fdc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  rx_byte,
    input  logic        pop,
    input  logic        empty,
    input  logic [1:0]  kind,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  node_id,
    input  logic [7:0]  msg_type,
    input  logic [7:0]  resp_flag,
    input  logic        from_slave,
    input  logic [15:0] payload_count,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output int          fail_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import fdc_pkg::*;

    // Parser phases of the predicted deframer.
    typedef enum logic [3:0] {
        ST_HUNT,
        ST_ID,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_TYPE,
        ST_FLAG,
        ST_PAYLOAD,
        ST_CRC_HI,
        ST_CRC_LO
    } parse_state_t;

    cfg_t         regs;
    parse_state_t state;
    logic [7:0]   cand_byte;
    logic         cand_valid;
    logic         slave_frame;
    logic [7:0]   id_q;
    logic [15:0]  len_q;
    logic [16:0]  remaining;
    logic [7:0]   type_q;
    logic [7:0]   flag_q;
    logic [15:0]  crc_acc;
    logic [7:0]   crc_hi_q;
    logic [15:0]  payload_q;
    result_t      expected_results[$];
    int           mismatches;

    // Reflected CRC-16/MODBUS, one bit per iteration.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        logic        lsb;
        acc = crc;
        for (int k = 0; k < 8; k++) begin
            lsb = acc[0] ^ b[k];
            acc = acc >> 1;
            if (lsb) begin
                acc = acc ^ 16'hA001;
            end
        end
        return acc;
    endfunction

    // Queue one expected result built from the current frame fields.
    function void queue_result(input kind_t k, input logic [7:0] d);
        result_t r;
        r.kind          = k;
        r.data_byte     = d;
        r.node_id       = id_q;
        r.msg_type      = type_q;
        r.resp_flag     = flag_q;
        r.from_slave    = slave_frame;
        r.payload_count = payload_q;
        expected_results.push_back(r);
    endfunction

    // Return to header hunting with no candidate byte held.
    function void restart_hunt();
        state      = ST_HUNT;
        cand_valid = 1'b0;
        cand_byte  = 8'h00;
    endfunction

    // Clear all parser state to its reset values.
    function void clear_parser();
        restart_hunt();
        slave_frame = 1'b0;
        id_q        = 8'h00;
        len_q       = 16'h0000;
        remaining   = 17'd0;
        type_q      = 8'h00;
        flag_q      = 8'h00;
        crc_acc     = 16'hFFFF;
        crc_hi_q    = 8'h00;
        payload_q   = 16'h0000;
    endfunction

    // Advance the predicted deframer by one accepted byte.
    function void deframe_byte(input logic [7:0] b);
        logic [16:0] total;
        logic        m_hit;
        logic        s_hit;
        case (state)
            ST_ID:
            begin
                id_q    = b;
                crc_acc = crc_step(crc_acc, b);
                state   = ST_LEN_HI;
            end
            ST_LEN_HI:
            begin
                len_q   = {b, 8'h00};
                crc_acc = crc_step(crc_acc, b);
                state   = ST_LEN_LO;
            end
            ST_LEN_LO:
            begin
                len_q   = {len_q[15:8], b};
                crc_acc = crc_step(crc_acc, b);
                total   = {1'b0, len_q} + {13'd0, regs.length_adjust};
                if (total < 17'd10) begin
                    queue_result(KIND_SHORT, 8'h00);
                    restart_hunt();
                end else begin
                    remaining = total - 17'd9;
                    state     = ST_TYPE;
                end
            end
            ST_TYPE:
            begin
                type_q  = b;
                crc_acc = crc_step(crc_acc, b);
                state   = ST_FLAG;
            end
            ST_FLAG:
            begin
                flag_q  = b;
                crc_acc = crc_step(crc_acc, b);
                state   = (remaining != 17'd0) ? ST_PAYLOAD : ST_CRC_HI;
            end
            ST_PAYLOAD:
            begin
                crc_acc = crc_step(crc_acc, b);
                if (payload_q != 16'hFFFF) begin
                    payload_q = payload_q + 16'd1;
                end
                if (remaining != 17'd0) begin
                    remaining = remaining - 17'd1;
                end
                if (remaining == 17'd0) begin
                    state = ST_CRC_HI;
                end
                queue_result(KIND_PAYLOAD, b);
            end
            ST_CRC_HI:
            begin
                crc_hi_q = b;
                state    = ST_CRC_LO;
            end
            ST_CRC_LO:
            begin
                queue_result(({crc_hi_q, b} == crc_acc) ? KIND_ACCEPTED : KIND_CRC_ERR, 8'h00);
                restart_hunt();
            end
            default:
            begin
                // Hunting: the master header wins when both match.
                m_hit = cand_valid && cand_byte == regs.master_first && b == regs.master_second;
                s_hit = cand_valid && cand_byte == regs.slave_first && b == regs.slave_second;
                if (m_hit || s_hit) begin
                    clear_parser();
                    slave_frame = !m_hit;
                    state       = ST_ID;
                end else begin
                    state      = ST_HUNT;
                    cand_byte  = b;
                    cand_valid = 1'b1;
                end
            end
        endcase
    endfunction

    // Apply one register write to the predicted configuration.
    function void write_register(input logic [2:0] idx, input logic [7:0] d);
        case (idx)
            CFG_MASTER_FIRST:  regs.master_first  = d;
            CFG_MASTER_SECOND: regs.master_second = d;
            CFG_SLAVE_FIRST:   regs.slave_first   = d;
            CFG_SLAVE_SECOND:  regs.slave_second  = d;
            CFG_LENGTH_ADJUST: regs.length_adjust = d[3:0];
            default: ;
        endcase
    endfunction

    function void compare_field(input string name, input int unsigned exp, input int unsigned act);
        if (exp != act) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
            mismatches++;
        end
    endfunction

    // Compare one popped item against the oldest expectation.
    function void check_result();
        result_t exp;
        if (expected_results.size() == 0) begin
            $error("kind: expected no item, got 0x%0h", kind);
            mismatches++;
        end else begin
            exp = expected_results.pop_front();
            compare_field("kind", exp.kind, kind);
            compare_field("data_byte", exp.data_byte, data_byte);
            compare_field("node_id", exp.node_id, node_id);
            compare_field("msg_type", exp.msg_type, msg_type);
            compare_field("resp_flag", exp.resp_flag, resp_flag);
            compare_field("from_slave", exp.from_slave, from_slave);
            compare_field("payload_count", exp.payload_count, payload_count);
        end
    endfunction

    // Results leave before the byte of this edge is predicted.
    always @(posedge clk) begin
        if (!rst_n) begin
            regs.master_first  = 8'hAA;
            regs.master_second = 8'h55;
            regs.slave_first   = 8'h55;
            regs.slave_second  = 8'hAA;
            regs.length_adjust = 4'd1;
            clear_parser();
            expected_results.delete();
            mismatches = 0;
        end else begin
            if (pop && !empty) begin
                check_result();
            end
            if (cfg_valid && cfg_ready) begin
                write_register(cfg_index, cfg_data);
            end
            if (push && !full) begin
                deframe_byte(rx_byte);
            end
        end
        outstanding <= expected_results.size();
        fail_count  <= mismatches;
    end

endmodule

[verif/tb_frame_deframer_crc16_check.sv]
// Testbench top for the frame deframer: drives frames and configuration, gives the verdict.
module tb_frame_deframer_crc16_check;
    timeunit 1ns;
    timeprecision 1ps;
    import fdc_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic [7:0]  rx_byte = 8'h00;
    logic        pop = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = CFG_MASTER_FIRST;
    logic [7:0]  cfg_data = 8'h00;
    logic        full;
    logic        empty;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  node_id;
    logic [7:0]  msg_type;
    logic [7:0]  resp_flag;
    logic        from_slave;
    logic [15:0] payload_count;
    logic        cfg_ready;
    int          fail_count;
    int          outstanding;

    // Odds of an idle burst are one in idle_rate; zero turns idling off.
    int          idle_rate = 4;
    int          pop_hold = 0;
    int          cycles = 0;
    int          frame_bytes = 0;

    // Copy of the header and length settings used to build frames.
    logic [7:0]  m_first = 8'hAA;
    logic [7:0]  m_second = 8'h55;
    logic [7:0]  s_first = 8'h55;
    logic [7:0]  s_second = 8'hAA;
    logic [3:0]  adj = 4'd1;

    frame_deframer_crc16_check dut (.*);
    fdc_checker chk (.*);

    always #1 clk = ~clk;

    // Abort a hung run.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: pop is held low in bursts of random length.
    always @(posedge clk) begin
        if (!rst_n) begin
            pop <= 1'b0;
        end else if (pop_hold > 0) begin
            pop_hold <= pop_hold - 1;
            pop <= 1'b0;
        end else if (idle_rate != 0 && $urandom_range(1, idle_rate) == 1) begin
            pop_hold <= $urandom_range(0, 4);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // Offer one byte, possibly after an idle burst, and wait until it is taken.
    task automatic send_byte(input logic [7:0] b);
        if (idle_rate != 0 && $urandom_range(1, idle_rate) == 1) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        push <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (full);
    endtask

    task automatic send_crc_byte(input logic [7:0] b, inout logic [15:0] crc);
        crc = crc_byte(crc, b);
        send_byte(b);
    endtask

    task automatic send_header(input bit slave);
        send_byte(slave ? s_first : m_first);
        send_byte(slave ? s_second : m_second);
    endtask

    // Complete frame with max(npay, 1, adj - 9) payload bytes, optionally with a corrupted CRC.
    task automatic send_frame(input bit slave, input int npay, input bit bad_crc);
        logic [15:0] crc;
        logic [15:0] len_field;
        int          n;
        n = npay;
        if (n < 1) begin
            n = 1;
        end
        if (n < int'(adj) - 9) begin
            n = int'(adj) - 9;
        end
        len_field = 16'(n + 9 - int'(adj));
        crc = 16'hFFFF;
        send_header(slave);
        send_crc_byte(8'($urandom_range(0, 255)), crc);
        send_crc_byte(len_field[15:8], crc);
        send_crc_byte(len_field[7:0], crc);
        send_crc_byte(8'($urandom_range(0, 255)), crc);
        send_crc_byte(8'($urandom_range(0, 255)), crc);
        for (int i = 0; i < n; i++) begin
            send_crc_byte(8'($urandom_range(0, 255)), crc);
        end
        if (bad_crc) begin
            crc = crc ^ 16'($urandom_range(1, 65535));
        end
        send_byte(crc[15:8]);
        send_byte(crc[7:0]);
        frame_bytes += n + 9;
    endtask

    // Header, id and a length that is too small; falls back to a full frame when
    // the adjustment makes a short one impossible.
    task automatic send_short(input bit slave);
        if (adj > 4'd9) begin
            send_frame(slave, int'($urandom_range(1, 8)), 1'b0);
        end else begin
            send_header(slave);
            send_byte(8'($urandom_range(0, 255)));
            send_byte(8'h00);
            send_byte(8'($urandom_range(0, 9 - int'(adj))));
            frame_bytes += 5;
        end
    endtask

    // Frame cut off after the length field and up to six more bytes; what follows is eaten as its tail.
    task automatic send_broken(input bit slave);
        int cut;
        cut = $urandom_range(0, 6);
        send_header(slave);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'h00);
        send_byte(8'($urandom_range(0, 255)));
        for (int i = 0; i < cut; i++) begin
            send_byte(8'($urandom_range(0, 255)));
        end
        frame_bytes += cut + 5;
    endtask

    // Mostly well-formed frames, with short, broken and noise items mixed in.
    task automatic run_traffic(input int budget);
        int pick;
        int stop_at;
        stop_at = frame_bytes + budget;
        while (frame_bytes < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_frame(1'($urandom_range(0, 1)),
                           int'(($urandom_range(0, 9) == 0) ? $urandom_range(17, 80)
                                                            : $urandom_range(1, 16)),
                           $urandom_range(0, 5) == 0);
            end else if (pick < 80) begin
                send_short(1'($urandom_range(0, 1)));
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end else begin
                send_broken(1'($urandom_range(0, 1)));
            end
        end
        push <= 1'b0;
    endtask

    // Wait until every expected item has come out.
    task automatic wait_drained();
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_MASTER_FIRST:  m_first = d;
            CFG_MASTER_SECOND: m_second = d;
            CFG_SLAVE_FIRST:   s_first = d;
            CFG_SLAVE_SECOND:  s_second = d;
            CFG_LENGTH_ADJUST: adj = d[3:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] mf, input logic [7:0] ms, input logic [7:0] sf,
                              input logic [7:0] ss, input logic [7:0] adj_data);
        write_reg(CFG_MASTER_FIRST, mf);
        write_reg(CFG_MASTER_SECOND, ms);
        write_reg(CFG_SLAVE_FIRST, sf);
        write_reg(CFG_SLAVE_SECOND, ss);
        write_reg(CFG_LENGTH_ADJUST, adj_data);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [7:0] a;
        logic [7:0] b;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames on the reset configuration: a stray header byte before
        // a minimal frame, a slave frame with a bad CRC, a short frame and a good slave frame.
        send_byte(m_first);
        send_frame(1'b0, 1, 1'b0);
        send_frame(1'b1, 3, 1'b1);
        send_short(1'b0);
        send_frame(1'b1, 2, 1'b0);
        push <= 1'b0;
        wait_drained();

        // Random traffic under a series of header and length settings.
        for (int p = 0; p < 6; p++) begin
            idle_rate = (p % 3 == 0) ? 4 : ((p % 3 == 1) ? 12 : 0);
            a = 8'($urandom_range(0, 255));
            b = 8'($urandom_range(0, 255));
            case (p)
                0: set_config(8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00);
                1: set_config(8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF);
                2: set_config(a, b, a, b, 8'($urandom_range(0, 9)));
                3: set_config(a, b, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
                4: set_config(a, b, a, ~b, 8'd9);
                default:
                begin
                    for (int i = CFG_LENGTH_ADJUST + 1; i < 8; i++) begin
                        write_reg(3'(i), 8'($urandom_range(0, 255)));
                    end
                    set_config(a, b, ~a, 8'($urandom_range(0, 255)), 8'hF1);
                end
            endcase
            run_traffic(280);
            wait_drained();
        end

        // No idling from here on; the largest adjustment with a long frame.
        idle_rate = 0;
        write_reg(CFG_LENGTH_ADJUST, 8'h0F);
        cfg_valid <= 1'b0;
        send_frame(1'b0, 40, 1'b0);
        send_frame(1'b1, 6, 1'b0);
        send_frame(1'b0, 7, 1'b1);
        push <= 1'b0;

        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
